// ----- rtl/core/ccw_pkg.sv -----
// Shared constants and types for the coin change way counter.
// Used by the saturating adder and the top level; no dependencies.
`default_nettype none

package ccw_pkg;

	localparam int OP_W      = 2;
	localparam int VALUE_W   = 10;
	localparam int STATUS_W  = 2;
	localparam int WAYS_W    = 32;
	localparam int ENTRY_W   = WAYS_W + 1;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = OP_W;
	localparam int M_TDATA_W = WAYS_W;
	localparam int M_TUSER_W = STATUS_W + 1;

	localparam int MAX_COINS_DEF  = 16;
	localparam int MAX_AMOUNT_DEF = 1023;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ENTRY_W-1:0]  entry_t;

	localparam op_t OP_APPEND = 2'd0;
	localparam op_t OP_CLEAR  = 2'd1;
	localparam op_t OP_QUERY  = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_FULL      = 2'd1;
	localparam status_t ST_ZERO_COIN = 2'd2;
	localparam status_t ST_RANGE     = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/core/ccw_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the coin store and the copies of the ways table.
`default_nettype none

module ccw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/ccw_sat_add.sv -----
// Shared saturating adder for ways table updates.
// Depends on ccw_pkg for the entry type; the sum clamps at 2^32.
`default_nettype none

module ccw_sat_add (
	input  wire ccw_pkg::entry_t a,
	input  wire ccw_pkg::entry_t b,
	output ccw_pkg::entry_t      sum
);

	import ccw_pkg::*;

	localparam logic [ENTRY_W:0] CAP = (ENTRY_W + 1)'(1) << WAYS_W;

	logic [ENTRY_W:0] raw;

	assign raw = {1'b0, a} + {1'b0, b};
	assign sum = (raw > CAP) ? CAP[ENTRY_W-1:0] : raw[ENTRY_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/coin_change_way_counter_top.sv -----
// Coin change way counter: append, clear and query on one request stream.
// Append, clear, unused and out-of-range requests: result registered in the cycle after the request.
// Query of amount A: clear entries 0..A, then per coin c <= A a read-add-write of each entry c..A
// through the single shared adder, larger coins skipped, then a final read of entry A.
// One request at a time; no new request is taken until the result is registered.
// arst_n clears the sequencer, the coin count and the output valid; tables are not cleared.
`default_nettype none

module coin_change_way_counter_top #(
	parameter int MAX_COINS  = ccw_pkg::MAX_COINS_DEF,
	parameter int MAX_AMOUNT = ccw_pkg::MAX_AMOUNT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [ccw_pkg::S_TDATA_W-1:0]   s_tdata,  // [9:0] value, rest zero
	input  wire logic [ccw_pkg::S_TUSER_W-1:0]   s_tuser,  // [1:0] operation
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [ccw_pkg::M_TDATA_W-1:0]   m_tdata,  // [31:0] ways
	output logic      [ccw_pkg::M_TUSER_W-1:0]   m_tuser   // [1:0] status, [2] saturated
);

	import ccw_pkg::*;

	localparam int AW  = $clog2(MAX_AMOUNT + 1);
	localparam int XW  = (AW > VALUE_W) ? AW : VALUE_W;
	localparam int CNW = $clog2(MAX_COINS + 1);
	localparam int IW  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLR   = 3'd1;
	localparam logic [2:0] S_CNEXT = 3'd2;
	localparam logic [2:0] S_CGET  = 3'd3;
	localparam logic [2:0] S_URD   = 3'd4;
	localparam logic [2:0] S_UWR   = 3'd5;
	localparam logic [2:0] S_FRD   = 3'd6;
	localparam logic [2:0] S_FGET  = 3'd7;

	logic [2:0]         state_q;
	logic [CNW-1:0]     count_q;
	logic [CNW-1:0]     k_q;
	logic [AW-1:0]      a_q;
	logic [AW-1:0]      amount_q;
	logic [AW-1:0]      coin_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [WAYS_W-1:0]  out_ways_q;
	logic               out_sat_q;

	op_t                req_op;
	logic [VALUE_W-1:0] req_value;
	logic               accept;
	logic               out_free;
	logic               coin_we;
	logic [VALUE_W-1:0] coin_rdata;
	logic               ways_we;
	entry_t             ways_wdata;
	entry_t             rd_cur;
	entry_t             rd_back;
	entry_t             upd_sum;
	logic [AW-1:0]      back_addr;

	assign req_op    = s_tuser;
	assign req_value = s_tdata[VALUE_W-1:0];
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;

	assign coin_we = accept && (req_op == OP_APPEND) && (req_value != '0)
		&& (count_q != CNW'(MAX_COINS));

	ccw_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COINS)) u_coin_store (
		.clk   (clk),
		.we    (coin_we),
		.waddr (count_q[IW-1:0]),
		.wdata (req_value),
		.raddr (k_q[IW-1:0]),
		.rdata (coin_rdata)
	);

	// The table is kept twice so ways[a] and ways[a-c] can be read together.
	assign back_addr  = a_q - coin_q;
	assign ways_we    = (state_q == S_CLR) || (state_q == S_UWR);
	assign ways_wdata = (state_q == S_CLR) ? ((a_q == '0) ? ENTRY_W'(1) : '0) : upd_sum;

	ccw_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_AMOUNT + 1)) u_ways_cur (
		.clk   (clk),
		.we    (ways_we),
		.waddr (a_q),
		.wdata (ways_wdata),
		.raddr (a_q),
		.rdata (rd_cur)
	);

	ccw_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_AMOUNT + 1)) u_ways_back (
		.clk   (clk),
		.we    (ways_we),
		.waddr (a_q),
		.wdata (ways_wdata),
		.raddr (back_addr),
		.rdata (rd_back)
	);

	ccw_sat_add u_add (
		.a   (rd_cur),
		.b   (rd_back),
		.sum (upd_sum)
	);

	// Sequencer and coin count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			k_q     <= '0;
			a_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (coin_we) begin
							count_q <= count_q + CNW'(1);
						end
						if (req_op == OP_CLEAR) begin
							count_q <= '0;
						end
						if ((req_op == OP_QUERY)
							&& (XW'(req_value) <= XW'(MAX_AMOUNT))) begin
							a_q     <= '0;
							state_q <= S_CLR;
						end
					end
				end
				S_CLR: begin
					if (a_q == amount_q) begin
						k_q     <= '0;
						state_q <= S_CNEXT;
					end else begin
						a_q <= a_q + AW'(1);
					end
				end
				S_CNEXT: begin
					if (k_q == count_q) begin
						a_q     <= amount_q;
						state_q <= S_FRD;
					end else begin
						state_q <= S_CGET;
					end
				end
				S_CGET: begin
					k_q <= k_q + CNW'(1);
					if (XW'(coin_rdata) > XW'(amount_q)) begin
						state_q <= S_CNEXT;
					end else begin
						a_q     <= AW'(coin_rdata);
						state_q <= S_URD;
					end
				end
				S_URD: begin
					state_q <= S_UWR;
				end
				S_UWR: begin
					if (a_q == amount_q) begin
						state_q <= S_CNEXT;
					end else begin
						a_q     <= a_q + AW'(1);
						state_q <= S_URD;
					end
				end
				S_FRD: begin
					state_q <= S_FGET;
				end
				S_FGET: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amount_q <= AW'(req_value);
		end
		if ((state_q == S_CGET) && (XW'(coin_rdata) <= XW'(amount_q))) begin
			coin_q <= AW'(coin_rdata);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && !((req_op == OP_QUERY)
			&& (XW'(req_value) <= XW'(MAX_AMOUNT)))) begin
			out_valid_q <= 1'b1;
		end else if ((state_q == S_FGET) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_ways_q <= '0;
			out_sat_q  <= 1'b0;
			case (req_op)
				OP_APPEND: begin
					if (req_value == '0) begin
						out_status_q <= ST_ZERO_COIN;
					end else if (count_q == CNW'(MAX_COINS)) begin
						out_status_q <= ST_FULL;
					end else begin
						out_status_q <= ST_OK;
					end
				end
				OP_QUERY: begin
					out_status_q <= (XW'(req_value) > XW'(MAX_AMOUNT)) ? ST_RANGE : ST_OK;
				end
				default: begin
					out_status_q <= ST_OK;
				end
			endcase
		end else if ((state_q == S_FGET) && out_free) begin
			out_status_q <= ST_OK;
			out_sat_q    <= rd_cur[WAYS_W];
			out_ways_q   <= rd_cur[WAYS_W] ? '1 : rd_cur[WAYS_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_ways_q;
	assign m_tuser  = {out_sat_q, out_status_q};

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNW'(MAX_COINS))
		else $error("coin count exceeds store depth");

	a_update_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UWR) |-> ((a_q >= coin_q) && (a_q <= amount_q)))
		else $error("table update outside coin..amount");

	a_sat_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[STATUS_W]) |-> (m_tdata == '1))
		else $error("saturated result without clamped count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[STATUS_W-1:0] != ST_OK))
		|-> ((m_tdata == '0) && !m_tuser[STATUS_W]))
		else $error("error result carries a count");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_op == OP_QUERY) && (req_value == '0)) |=> (state_q == S_CLR))
		else $error("in-range query did not start the table fill");
`endif

endmodule

`default_nettype wire
